@@ sv/gbp_pkg.sv @@
// Shared constants, types and controller/datapath interface structs for the
// grid broad-phase pair unit. No dependencies.
`timescale 1ns / 1ps

package gbp_pkg;

  localparam int MAX_BODIES      = 8;
  localparam int CELL_INDEX_BITS = 21;
  localparam int RESULT_CAP      = 28;

  localparam int COORD_W   = 32;
  localparam int INV_W     = 32;
  localparam int IDX_W     = (MAX_BODIES > 2) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W     = $clog2(MAX_BODIES + 1);
  localparam int FOUND_W   = $clog2(RESULT_CAP + 1);
  localparam int CELL_W    = 6 * CELL_INDEX_BITS;
  localparam int BODY_W    = 3;
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int OUT_DATA_W = 8;

  localparam logic [INV_W-1:0] INV_RESET = 32'd16384;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_DRAIN   = 7'b0000010,
    S_START   = 7'b0000100,
    S_READ_A  = 7'b0001000,
    S_LATCH_A = 7'b0010000,
    S_COMPARE = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load_en;
    logic walk_init;
    logic rd_a;
    logic latch_a;
    logic compare;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_taken;
    logic few_bodies;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic b_end;
    logic a_end;
    logic cap_next;
  } status_t;

endpackage

@@ sv/grid_broad_phase_pairs_unit.sv @@
// Top level of the grid broad-phase pair unit.
// Depends on gbp_pkg, gbp_ctrl and gbp_datapath.
`timescale 1ns / 1ps
//
// Usage:
//   Write the reciprocal cell size (unsigned Q16.16) on cfg_* while idle.
//   Stream boxes on s_* one request per cycle: tdata carries six signed
//   Q16.16 corners, tlast marks the final box of a set. Boxes beyond
//   capacity are discarded and flagged on every result of that set.
//   After the final box, s_tready drops while the stored pairs are walked:
//   the cells of each lower index are read and latched, then compared
//   with those of every higher index in turn.
//   Each overlapping pair waits in a pending register until the next
//   overlap or the finish; each result is held in m_* until taken.
//   Results are overlapping pairs in ascending order; m_tlast marks the
//   last, and an empty set gives one result with m_tuser low.
//   A stalled receiver stops the walk at the next overlap found while one
//   result is held in m_* and another pair is pending.
//   Reset clears the set, flags and handshakes and loads cell size 4;
//   the cell store contents are not cleared.
//

module grid_broad_phase_pairs_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbp_pkg::INV_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [gbp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // body_a, body_b, bodies_dropped, one zero pad bit
  output logic [gbp_pkg::OUT_DATA_W-1:0] m_tdata,
  // pair_valid
  output logic                           m_tuser,
  output logic                           m_tlast
);

  gbp_pkg::cmd_t    cmd;
  gbp_pkg::status_t st;

  assign cfg_ready = 1'b1;

  gbp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  gbp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ sv/gbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/gbp_ctrl.sv @@
// Sequencer for box loading, pair walk and result completion.
// Depends on gbp_pkg.
`timescale 1ns / 1ps

module gbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  gbp_pkg::status_t st,
  output gbp_pkg::cmd_t    cmd
);

  gbp_pkg::state_t state;
  gbp_pkg::state_t state_next;
  logic            advance;

  assign advance = !(st.hit && st.pend_valid && !st.out_free);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      gbp_pkg::S_LOAD: begin
        cmd.load_en = 1'b1;
        if (st.last_taken) begin
          state_next = gbp_pkg::S_DRAIN;
        end
      end
      gbp_pkg::S_DRAIN: begin
        state_next = gbp_pkg::S_START;
      end
      gbp_pkg::S_START: begin
        cmd.walk_init = 1'b1;
        state_next = st.few_bodies ? gbp_pkg::S_FINISH : gbp_pkg::S_READ_A;
      end
      gbp_pkg::S_READ_A: begin
        cmd.rd_a   = 1'b1;
        state_next = gbp_pkg::S_LATCH_A;
      end
      gbp_pkg::S_LATCH_A: begin
        cmd.latch_a = 1'b1;
        state_next  = gbp_pkg::S_COMPARE;
      end
      gbp_pkg::S_COMPARE: begin
        cmd.compare = 1'b1;
        cmd.advance = advance;
        if (advance) begin
          if ((st.hit && st.cap_next) || (st.b_end && st.a_end)) begin
            state_next = gbp_pkg::S_FINISH;
          end else if (st.b_end) begin
            state_next = gbp_pkg::S_READ_A;
          end
        end
      end
      gbp_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        if (st.out_free) begin
          state_next = gbp_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = gbp_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbp_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/gbp_datapath.sv @@
// Cell mapping pipeline, cell store, pair walk counters, overlap test and
// output register. Depends on gbp_pkg and gbp_ram.
`timescale 1ns / 1ps

module gbp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  gbp_pkg::cmd_t                       cmd,
  output gbp_pkg::status_t                    st,
  input  logic                                cfg_valid,
  input  logic [gbp_pkg::INV_W-1:0]           cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gbp_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gbp_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam int CIB = gbp_pkg::CELL_INDEX_BITS;
  localparam logic signed [31:0] QMIN = -(32'sd1 <<< (CIB - 1));
  localparam logic signed [31:0] QMAX = (32'sd1 <<< (CIB - 1)) - 32'sd1;

  logic [gbp_pkg::INV_W-1:0] inv_cell_size;

  logic                       accept;
  logic [gbp_pkg::CNT_W-1:0]  body_count;
  logic                       overflow;

  logic                       s1_valid;
  logic [gbp_pkg::IDX_W-1:0]  s1_slot;
  logic signed [31:0]         s1_q [6];
  logic signed [64:0]         prod [6];
  logic [gbp_pkg::CELL_W-1:0] wr_cells;

  logic                       ram_re;
  logic [gbp_pkg::IDX_W-1:0]  ram_raddr;
  logic [gbp_pkg::CELL_W-1:0] ram_rdata;

  logic [gbp_pkg::IDX_W-1:0]  walk_a;
  logic [gbp_pkg::IDX_W-1:0]  walk_b;
  logic [gbp_pkg::CELL_W-1:0] a_cells;
  logic [gbp_pkg::FOUND_W-1:0] found;

  logic                       pend_valid;
  logic [gbp_pkg::IDX_W-1:0]  pend_a;
  logic [gbp_pkg::IDX_W-1:0]  pend_b;

  logic                       out_valid;
  logic [gbp_pkg::IDX_W-1:0]  out_a;
  logic [gbp_pkg::IDX_W-1:0]  out_b;
  logic                       out_pair;
  logic                       out_last;
  logic                       out_drop;

  logic                       hit;
  logic                       out_free;
  logic                       b_end;
  logic                       a_end;
  logic                       push_pend;
  logic                       do_finish;

  function automatic logic [CIB-1:0] cell_field(input logic signed [31:0] q);
    logic signed [31:0] c;
    c = q;
    if (q < QMIN) begin
      c = QMIN;
    end else if (q > QMAX) begin
      c = QMAX;
    end
    return {~c[CIB-1], c[CIB-2:0]};
  endfunction

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cell_size <= gbp_pkg::INV_RESET;
    end else if (cfg_valid) begin
      inv_cell_size <= cfg_data;
    end
  end

  // Stage 1: corner times reciprocal, keep the floored integer part
  assign s_tready = cmd.load_en;
  assign accept   = s_tvalid && cmd.load_en;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod[k] = 65'($signed(s_tdata[k*gbp_pkg::COORD_W +: gbp_pkg::COORD_W]))
              * 65'($signed({1'b0, inv_cell_size}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (body_count < gbp_pkg::CNT_W'(gbp_pkg::MAX_BODIES));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot <= gbp_pkg::IDX_W'(body_count);
      for (int k = 0; k < 6; k++) begin
        s1_q[k] <= prod[k][63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_count <= '0;
      overflow   <= 1'b0;
    end else if (do_finish) begin
      body_count <= '0;
      overflow   <= 1'b0;
    end else if (accept) begin
      if (body_count < gbp_pkg::CNT_W'(gbp_pkg::MAX_BODIES)) begin
        body_count <= body_count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Stage 2: clamp, offset and store; word is lower x,y,z then upper x,y,z
  assign wr_cells = {cell_field(s1_q[0]), cell_field(s1_q[1]), cell_field(s1_q[2]),
                     cell_field(s1_q[3]), cell_field(s1_q[4]), cell_field(s1_q[5])};

  gbp_ram #(
    .WIDTH (gbp_pkg::CELL_W),
    .DEPTH (gbp_pkg::MAX_BODIES)
  ) u_cells (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_slot),
    .wdata (wr_cells),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pair walk
  assign b_end = gbp_pkg::CNT_W'(walk_b) == body_count - 1'b1;
  assign a_end = gbp_pkg::CNT_W'(walk_a) == body_count - gbp_pkg::CNT_W'(2);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = walk_b;
    if (cmd.rd_a) begin
      ram_re    = 1'b1;
      ram_raddr = walk_a;
    end else if (cmd.latch_a) begin
      ram_re    = 1'b1;
      ram_raddr = walk_b;
    end else if (cmd.advance && !b_end) begin
      ram_re    = 1'b1;
      ram_raddr = gbp_pkg::IDX_W'(walk_b + 1'b1);
    end
  end

  always_comb begin
    logic [CIB-1:0] la, lb, ha, hb, lo, hi;
    hit = cmd.compare;
    for (int ax = 0; ax < 3; ax++) begin
      la = a_cells[(5 - ax)*CIB +: CIB];
      lb = ram_rdata[(5 - ax)*CIB +: CIB];
      ha = a_cells[(2 - ax)*CIB +: CIB];
      hb = ram_rdata[(2 - ax)*CIB +: CIB];
      lo = (la > lb) ? la : lb;
      hi = (ha < hb) ? ha : hb;
      if (lo > hi) begin
        hit = 1'b0;
      end
    end
  end

  assign out_free  = !out_valid || m_tready;
  assign push_pend = cmd.advance && hit && pend_valid;
  assign do_finish = cmd.finish && out_free;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_a <= '0;
      walk_b <= gbp_pkg::IDX_W'(1);
    end else if (cmd.advance) begin
      if (b_end) begin
        if (!a_end) begin
          walk_a <= walk_a + 1'b1;
          walk_b <= gbp_pkg::IDX_W'(walk_a + 2'd2);
        end
      end else begin
        walk_b <= walk_b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      a_cells <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && hit) begin
      pend_a <= walk_a;
      pend_b <= walk_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (cmd.walk_init || do_finish) begin
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (cmd.advance && hit) begin
      pend_valid <= 1'b1;
      found      <= found + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend || do_finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend || do_finish) begin
      out_a    <= (push_pend || pend_valid) ? pend_a : '0;
      out_b    <= (push_pend || pend_valid) ? pend_b : '0;
      out_pair <= push_pend || pend_valid;
      out_last <= do_finish;
      out_drop <= overflow;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_drop, gbp_pkg::BODY_W'(out_b), gbp_pkg::BODY_W'(out_a)};
  assign m_tuser  = out_pair;
  assign m_tlast  = out_last;

  assign st.last_taken = accept && s_tlast;
  assign st.few_bodies = body_count < gbp_pkg::CNT_W'(2);
  assign st.hit        = hit;
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;
  assign st.b_end      = b_end;
  assign st.a_end      = a_end;
  assign st.cap_next   = found == gbp_pkg::FOUND_W'(gbp_pkg::RESULT_CAP - 1);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    body_count <= gbp_pkg::CNT_W'(gbp_pkg::MAX_BODIES))
    else $error("body count above capacity");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pair |-> out_a < out_b)
    else $error("pair indices out of order");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pair |-> out_last)
    else $error("empty result not marked last");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |-> walk_b > walk_a)
    else $error("walk index b not above a");

endmodule
